FILE: src/light_grid_bucket_allocator_macros.svh
// ----------------------------------------------------------------------------
// Light grid bucket allocator assertion macros
// Concurrent check helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIGHT_GRID_BUCKET_ALLOCATOR_MACROS_SVH
`define LIGHT_GRID_BUCKET_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LGBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define LGBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`define LGBA_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LGBA_ASSERT_IMP(label, ante, cons)
`define LGBA_ASSERT_NEXT(label, ante, cons)
`define LGBA_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: src/lgba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light grid bucket allocator package
// Shared constants, codes, types and the per-axis bucket count function.
// ----------------------------------------------------------------------------
package lgba_pkg;

    localparam int MAX_GROUPS_PER_AXIS   = 64;
    localparam int VOXELS_PER_GROUP_AXIS = 16;

    localparam int TABLE_AW    = 18;
    localparam int TABLE_DEPTH = 2 ** TABLE_AW;
    localparam int COORD_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int OFFSET_W    = 31;
    localparam int ENTRY_OFS_W = 30;
    localparam int FRESH_W     = 19;
    localparam int EXTENT_W    = 18;
    localparam int CFG_IDX_W   = 3;

    localparam logic [OFFSET_W-1:0] OFFSET_STEP =
        OFFSET_W'(VOXELS_PER_GROUP_AXIS * VOXELS_PER_GROUP_AXIS * VOXELS_PER_GROUP_AXIS);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT   = 3'd6;

    localparam logic [31:0] SCALE_RESET = 32'd65536;

    typedef struct packed {
        logic                   valid;
        logic [ENTRY_OFS_W-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic                wr_en;
        logic [TABLE_AW-1:0] wr_addr;
        entry_t              wr_data;
        logic                rd_en;
        logic [TABLE_AW-1:0] rd_addr;
    } tbl_req_t;

    typedef struct packed {
        logic [2:0][31:0]    origin;
        logic [2:0][31:0]    scale;
        logic [EXTENT_W-1:0] extent;
    } grid_cfg_t;

    typedef struct packed {
        logic                    done;
        logic                    err;
        logic [2:0][COORD_W-1:0] lo;
        logic [2:0][COORD_W-1:0] hi;
    } map_res_t;

    function automatic logic [COUNT_W-1:0] axis_count(input logic [COORD_W-1:0] field);
        logic [COUNT_W-1:0] c;
        c = {1'b0, field} + COUNT_W'(1);
        if (c > COUNT_W'(MAX_GROUPS_PER_AXIS))
        begin
            c = COUNT_W'(MAX_GROUPS_PER_AXIS);
        end
        return c;
    endfunction

endpackage

FILE: src/light_grid_bucket_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light grid bucket allocator
// Maps light boxes into grid buckets and hands out element offsets to every
// bucket that is not yet allocated; also clears the table and reads entries.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_stall    opcode, min_x..max_z, bucket_index
//  result    out_valid / out_stall  entry_valid, entry_offset, total_elements,
//                                   new_buckets, range_error
//  config    cfg_wr_en              cfg_index, cfg_wdata
//
//  In an insert inside the grid, each bucket of its box is one registered read
//  and one write-back of the table memory. A clear sweeps the whole table.
//  After reset the table is swept with in_stall high.
//  A new item is taken while a finished result still waits in the output
//  register; its own result waits until that register is free.
// ----------------------------------------------------------------------------
module light_grid_bucket_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lgba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic signed [31:0]                min_x,
    input  logic signed [31:0]                min_y,
    input  logic signed [31:0]                min_z,
    input  logic signed [31:0]                max_x,
    input  logic signed [31:0]                max_y,
    input  logic signed [31:0]                max_z,
    input  logic [lgba_pkg::TABLE_AW-1:0]     bucket_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              entry_valid,
    output logic [lgba_pkg::ENTRY_OFS_W-1:0]  entry_offset,
    output logic [lgba_pkg::OFFSET_W-1:0]     total_elements,
    output logic [lgba_pkg::FRESH_W-1:0]      new_buckets,
    output logic                              range_error
);
    import lgba_pkg::*;

    grid_cfg_t        cfg_reg;
    logic [2:0][31:0] corner_a;
    logic [2:0][31:0] corner_b;
    logic             map_start;
    map_res_t         map_res;
    tbl_req_t         tbl_req;
    entry_t           rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin <= '0;
            cfg_reg.scale  <= {SCALE_RESET, SCALE_RESET, SCALE_RESET};
            cfg_reg.extent <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin[0] <= cfg_wdata;
                REG_ORIGIN_Y: cfg_reg.origin[1] <= cfg_wdata;
                REG_ORIGIN_Z: cfg_reg.origin[2] <= cfg_wdata;
                REG_SCALE_X:  cfg_reg.scale[0]  <= cfg_wdata;
                REG_SCALE_Y:  cfg_reg.scale[1]  <= cfg_wdata;
                REG_SCALE_Z:  cfg_reg.scale[2]  <= cfg_wdata;
                REG_EXTENT:   cfg_reg.extent    <= cfg_wdata[EXTENT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign corner_a = {min_z, min_y, min_x};
    assign corner_b = {max_z, max_y, max_x};

    lgba_mapper u_mapper (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (map_start),
        .cfg      (cfg_reg),
        .corner_a (corner_a),
        .corner_b (corner_b),
        .res      (map_res)
    );

    lgba_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (rd_entry)
    );

    lgba_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .bucket_index   (bucket_index),
        .extent         (cfg_reg.extent),
        .map_start      (map_start),
        .map_res        (map_res),
        .tbl_req        (tbl_req),
        .rd_entry       (rd_entry),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_valid    (entry_valid),
        .entry_offset   (entry_offset),
        .total_elements (total_elements),
        .new_buckets    (new_buckets),
        .range_error    (range_error)
    );

endmodule

FILE: src/lgba_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgba_table (
    input  logic              clk,
    input  lgba_pkg::tbl_req_t req,
    output lgba_pkg::entry_t   rd_data
);
    import lgba_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/lgba_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Corner to bucket mapper
// Orders the bounds per axis, then maps the six corner values one per cycle
// through a subtract, magnitude, multiply and range check pipeline.
// ----------------------------------------------------------------------------
module lgba_mapper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lgba_pkg::grid_cfg_t cfg,
    input  logic [2:0][31:0]   corner_a,
    input  logic [2:0][31:0]   corner_b,
    output lgba_pkg::map_res_t  res
);
    import lgba_pkg::*;

    localparam logic [2:0] CORNER_LAST = 3'd5;

    logic [2:0][31:0]        lo_p_reg;
    logic [2:0][31:0]        hi_p_reg;
    logic [2:0][31:0]        lo_p_next;
    logic [2:0][31:0]        hi_p_next;
    logic [2:0]              step_reg;
    logic [2:0]              step_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    va_reg;
    logic                    vb_reg;
    logic                    vc_reg;
    logic                    done_reg;
    logic                    err_reg;
    logic [2:0]              tag_a_reg;
    logic [2:0]              tag_b_reg;
    logic [2:0]              tag_c_reg;
    logic [32:0]             d_reg;
    logic [31:0]             mag_reg;
    logic [31:0]             scale_b_reg;
    logic [31:0]             q_reg;
    logic                    neg_b_reg;
    logic                    neg_c_reg;
    logic [5:0][COORD_W-1:0] coord_reg;

    logic [1:0]              axis_a;
    logic [1:0]              axis_c;
    logic [31:0]             p_sel;
    logic [31:0]             org_sel;
    logic [32:0]             d_sel;
    logic [32:0]             mag_full;
    logic [63:0]             prod;
    logic [COUNT_W-1:0]      count_c;
    logic                    bad;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(corner_a[a]) > $signed(corner_b[a]))
            begin
                lo_p_next[a] = corner_b[a];
                hi_p_next[a] = corner_a[a];
            end
            else
            begin
                lo_p_next[a] = corner_a[a];
                hi_p_next[a] = corner_b[a];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == CORNER_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign axis_a   = step_reg[2:1];
    assign p_sel    = step_reg[0] ? hi_p_reg[axis_a] : lo_p_reg[axis_a];
    assign org_sel  = cfg.origin[axis_a];
    assign d_sel    = {p_sel[31], p_sel} - {org_sel[31], org_sel};
    assign mag_full = d_reg[32] ? (33'd0 - d_reg) : d_reg;
    assign prod     = mag_reg * scale_b_reg;
    assign axis_c   = tag_c_reg[2:1];
    assign count_c  = axis_count(cfg.extent[6 * axis_c +: COORD_W]);
    assign bad      = (neg_c_reg && (q_reg != 32'd0)) || (q_reg >= {25'd0, count_c});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            va_reg   <= busy_reg;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            done_reg <= vc_reg && (tag_c_reg == CORNER_LAST);
            if (start)
            begin
                err_reg <= 1'b0;
            end
            else if (vc_reg && bad)
            begin
                err_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_p_reg <= lo_p_next;
            hi_p_reg <= hi_p_next;
        end
        d_reg       <= d_sel;
        tag_a_reg   <= step_reg;
        mag_reg     <= mag_full[31:0];
        neg_b_reg   <= d_reg[32];
        scale_b_reg <= cfg.scale[tag_a_reg[2:1]];
        tag_b_reg   <= tag_a_reg;
        q_reg       <= prod[63:32];
        neg_c_reg   <= neg_b_reg;
        tag_c_reg   <= tag_b_reg;
        if (vc_reg)
        begin
            coord_reg[tag_c_reg] <= q_reg[COORD_W-1:0];
        end
    end

    assign res.done  = done_reg;
    assign res.err   = err_reg;
    assign res.lo[0] = coord_reg[0];
    assign res.hi[0] = coord_reg[1];
    assign res.lo[1] = coord_reg[2];
    assign res.hi[1] = coord_reg[3];
    assign res.lo[2] = coord_reg[4];
    assign res.hi[2] = coord_reg[5];

endmodule

FILE: src/lgba_ctrl.sv
`timescale 1ns / 1ps
`include "light_grid_bucket_allocator_macros.svh"
// ----------------------------------------------------------------------------
// Bucket allocator sequencer
// Runs the clearing sweep, the bucket walk with read-modify-write of the
// table, bucket reads, and the output register.
// ----------------------------------------------------------------------------
module lgba_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [lgba_pkg::TABLE_AW-1:0]     bucket_index,
    input  logic [lgba_pkg::EXTENT_W-1:0]     extent,
    output logic                              map_start,
    input  lgba_pkg::map_res_t                 map_res,
    output lgba_pkg::tbl_req_t                 tbl_req,
    input  lgba_pkg::entry_t                   rd_entry,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              entry_valid,
    output logic [lgba_pkg::ENTRY_OFS_W-1:0]  entry_offset,
    output logic [lgba_pkg::OFFSET_W-1:0]     total_elements,
    output logic [lgba_pkg::FRESH_W-1:0]      new_buckets,
    output logic                              range_error
);
    import lgba_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLEAR     = 4'd1;
    localparam logic [3:0] ST_MAP_WAIT  = 4'd2;
    localparam logic [3:0] ST_INIT1     = 4'd3;
    localparam logic [3:0] ST_INIT2     = 4'd4;
    localparam logic [3:0] ST_INIT3     = 4'd5;
    localparam logic [3:0] ST_WALK_RD   = 4'd6;
    localparam logic [3:0] ST_WALK_WR   = 4'd7;
    localparam logic [3:0] ST_READ_WAIT = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam logic [TABLE_AW-1:0] TABLE_LAST = '1;

    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic [TABLE_AW-1:0]    clr_addr_reg;
    logic [TABLE_AW-1:0]    clr_addr_next;
    logic                   clr_report_reg;
    logic                   clr_report_next;
    logic [OFFSET_W-1:0]    next_offset_reg;
    logic [OFFSET_W-1:0]    next_offset_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [COORD_W-1:0]     x_reg;
    logic [COORD_W-1:0]     y_reg;
    logic [COORD_W-1:0]     z_reg;
    logic [12:0]            plane_reg;
    logic [11:0]            rowoff_reg;
    logic [TABLE_AW-1:0]    zoff_reg;
    logic [TABLE_AW-1:0]    idx_reg;
    logic [TABLE_AW-1:0]    idx_x_reg;
    logic [TABLE_AW-1:0]    idx_y_reg;
    logic [FRESH_W-1:0]     fresh_reg;
    logic                   err_reg;
    logic                   res_valid_reg;
    logic [ENTRY_OFS_W-1:0] res_offset_reg;
    logic                   entry_valid_reg;
    logic [ENTRY_OFS_W-1:0] entry_offset_reg;
    logic [OFFSET_W-1:0]    total_reg;
    logic [FRESH_W-1:0]     new_buckets_reg;
    logic                   range_error_reg;

    logic                   accept;
    logic                   out_free;
    logic                   alloc;
    logic                   x_last;
    logic                   y_last;
    logic                   z_last;
    logic [COUNT_W-1:0]     nx;
    logic [COUNT_W-1:0]     ny;
    logic [13:0]            plane_full;
    logic [12:0]            rowoff_full;
    logic [18:0]            zoff_full;
    logic [TABLE_AW-1:0]    idx_start;
    logic [TABLE_AW-1:0]    idx_x_step;
    logic [TABLE_AW-1:0]    idx_y_step;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign alloc       = (state_reg == ST_WALK_WR) && !rd_entry.valid;
    assign x_last      = (x_reg == map_res.hi[0]);
    assign y_last      = (y_reg == map_res.hi[1]);
    assign z_last      = (z_reg == map_res.hi[2]);
    assign nx          = axis_count(extent[COORD_W-1:0]);
    assign ny          = axis_count(extent[2*COORD_W-1:COORD_W]);
    assign plane_full  = nx * ny;
    assign rowoff_full = nx * map_res.lo[1];
    assign zoff_full   = plane_reg * map_res.lo[2];
    assign idx_start   = {12'd0, map_res.lo[0]} + {6'd0, rowoff_reg} + zoff_reg;
    assign idx_x_step  = idx_x_reg + TABLE_AW'(1);
    assign idx_y_step  = idx_y_reg + {11'd0, nx};
    assign map_start   = accept && (opcode == OP_INSERT);

    always_comb
    begin
        tbl_req.wr_en   = (state_reg == ST_CLEAR) || alloc;
        tbl_req.wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
        tbl_req.wr_data = '0;
        if (state_reg != ST_CLEAR)
        begin
            tbl_req.wr_data.valid  = 1'b1;
            tbl_req.wr_data.offset = next_offset_reg[ENTRY_OFS_W-1:0];
        end
        tbl_req.rd_en   = (accept && (opcode == OP_READ)) || (state_reg == ST_WALK_RD);
        tbl_req.rd_addr = (state_reg == ST_IDLE) ? bucket_index : idx_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        clr_report_next  = clr_report_reg;
        next_offset_next = next_offset_reg;
        out_valid_next   = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            state_next       = ST_CLEAR;
                            clr_addr_next    = '0;
                            clr_report_next  = 1'b1;
                            next_offset_next = '0;
                        end
                        OP_INSERT: state_next = ST_MAP_WAIT;
                        OP_READ:   state_next = ST_READ_WAIT;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + TABLE_AW'(1);
                if (clr_addr_reg == TABLE_LAST)
                begin
                    state_next      = clr_report_reg ? ST_DONE : ST_IDLE;
                    clr_report_next = 1'b0;
                end
            end
            ST_MAP_WAIT:
            begin
                if (map_res.done)
                begin
                    state_next = map_res.err ? ST_DONE : ST_INIT1;
                end
            end
            ST_INIT1:     state_next = ST_INIT2;
            ST_INIT2:     state_next = ST_INIT3;
            ST_INIT3:     state_next = ST_WALK_RD;
            ST_WALK_RD:   state_next = ST_WALK_WR;
            ST_WALK_WR:
            begin
                if (alloc)
                begin
                    next_offset_next = next_offset_reg + OFFSET_STEP;
                end
                state_next = (x_last && y_last && z_last) ? ST_DONE : ST_WALK_RD;
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            clr_report_reg  <= 1'b0;
            next_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            clr_report_reg  <= clr_report_next;
            next_offset_reg <= next_offset_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fresh_reg      <= '0;
                    err_reg        <= 1'b0;
                    res_valid_reg  <= 1'b0;
                    res_offset_reg <= '0;
                end
            end
            ST_MAP_WAIT:
            begin
                if (map_res.done)
                begin
                    err_reg <= map_res.err;
                    x_reg   <= map_res.lo[0];
                    y_reg   <= map_res.lo[1];
                    z_reg   <= map_res.lo[2];
                end
            end
            ST_INIT1:
            begin
                plane_reg  <= plane_full[12:0];
                rowoff_reg <= rowoff_full[11:0];
            end
            ST_INIT2:
            begin
                zoff_reg <= zoff_full[TABLE_AW-1:0];
            end
            ST_INIT3:
            begin
                idx_reg   <= idx_start;
                idx_x_reg <= idx_start;
                idx_y_reg <= idx_start;
            end
            ST_WALK_WR:
            begin
                if (alloc)
                begin
                    fresh_reg <= fresh_reg + FRESH_W'(1);
                end
                if (!z_last)
                begin
                    z_reg   <= z_reg + COORD_W'(1);
                    idx_reg <= idx_reg + {5'd0, plane_reg};
                end
                else if (!y_last)
                begin
                    y_reg     <= y_reg + COORD_W'(1);
                    z_reg     <= map_res.lo[2];
                    idx_y_reg <= idx_y_step;
                    idx_reg   <= idx_y_step;
                end
                else if (!x_last)
                begin
                    x_reg     <= x_reg + COORD_W'(1);
                    y_reg     <= map_res.lo[1];
                    z_reg     <= map_res.lo[2];
                    idx_x_reg <= idx_x_step;
                    idx_y_reg <= idx_x_step;
                    idx_reg   <= idx_x_step;
                end
            end
            ST_READ_WAIT:
            begin
                res_valid_reg  <= rd_entry.valid;
                res_offset_reg <= rd_entry.valid ? rd_entry.offset : '0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    entry_valid_reg  <= res_valid_reg;
                    entry_offset_reg <= res_offset_reg;
                    total_reg        <= next_offset_reg;
                    new_buckets_reg  <= fresh_reg;
                    range_error_reg  <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign entry_valid    = entry_valid_reg;
    assign entry_offset   = entry_offset_reg;
    assign total_elements = total_reg;
    assign new_buckets    = new_buckets_reg;
    assign range_error    = range_error_reg;

    `LGBA_ASSERT_NEVER(a_wr_outside_sweep_or_walk, tbl_req.wr_en && (state_reg != ST_CLEAR) && (state_reg != ST_WALK_WR))
    `LGBA_ASSERT_IMP(a_map_done_while_waiting, map_res.done, state_reg == ST_MAP_WAIT)
    `LGBA_ASSERT_NEXT(a_offset_step, alloc, next_offset_reg == OFFSET_W'($past(next_offset_reg) + OFFSET_STEP))
    `LGBA_ASSERT_NEXT(a_out_only_from_done, !out_valid_reg && (state_reg != ST_DONE), !out_valid_reg)

endmodule
